// ===== hdl/lsb_stego_embedder_macros.svh =====
// ---------------------------------------------------------------------------
// lsb stego embedder assertion macros
// clocked on clk, quiet while rst is high
// ---------------------------------------------------------------------------
`ifndef LSB_STEGO_EMBEDDER_MACROS_SVH
`define LSB_STEGO_EMBEDDER_MACROS_SVH

// same-cycle implication
`define LSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lse_pkg.sv =====
// ---------------------------------------------------------------------------
// lse_pkg
// shared types and constants of the lsb stego embedder
// ---------------------------------------------------------------------------
package lse_pkg;

  localparam int unsigned MAX_MAGIC_CHARS = 8;
  localparam int unsigned MAX_EXT_CHARS   = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_CHARS  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_LEN    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXT_CHARS    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXT_LEN      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_SIZE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_LEN   = 3'd5;

  localparam logic [3:0] MAGIC_LEN_RST  = 4'd2;
  localparam logic [7:0] HEADER_LEN_RST = 8'd54;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_MAGIC   = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_EXT     = 3'd3,
    PH_PSIZE   = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DONE    = 3'd6
  } lse_phase_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_LOAD  = 1'b1
  } lse_op_t;

  typedef struct packed {
    logic       func;
    logic [7:0] byte_value;
  } lse_in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       status;
    logic       done_res;
  } lse_out_item_t;

  typedef struct packed {
    lse_op_t    op;
    logic [7:0] value;
  } lse_cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic     valid;
    lse_cmd_t cmd;
  } lse_head_t;

  typedef struct packed {
    logic [63:0] magic_chars;
    logic [3:0]  magic_len;
    logic [63:0] ext_chars;
    logic [3:0]  ext_len;
    logic [31:0] payload_size;
    logic [7:0]  header_len;
  } lse_cfg_t;

  typedef struct packed {
    lse_phase_t phase;
    logic       loaded;
  } lse_stat_t;

endpackage

// ===== hdl/lse_stream_if.sv =====
// ---------------------------------------------------------------------------
// lse_stream_if
// valid/ready channel carrying one item
// ---------------------------------------------------------------------------
interface lse_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/lse_front.sv =====
// ---------------------------------------------------------------------------
// lse_front
// accepts items, tags them as pixel or payload load, queues them
// ---------------------------------------------------------------------------
module lse_front #(
  parameter int unsigned QUEUE_DEPTH = lse_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  lse_stream_if.sink        item_in,
  output lse_pkg::lse_head_t head,
  input  logic              pop
);
  import lse_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  lse_cmd_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              take;
  lse_cmd_t          cmd_in;

  assign item_in.ready = (count != CNT_FULL);
  assign push          = item_in.valid && item_in.ready;
  assign take          = pop && head.valid;

  // classify
  assign cmd_in.op    = item_in.data.func ? OP_LOAD : OP_PIXEL;
  assign cmd_in.value = item_in.data.byte_value;

  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== hdl/lse_back.sv =====
// ---------------------------------------------------------------------------
// lse_back
// embedding sequencer: walks the message sections, holds the result register
// ---------------------------------------------------------------------------
module lse_back (
  input  logic               clk,
  input  logic               rst,
  input  lse_pkg::lse_cfg_t  cfg,
  input  lse_pkg::lse_head_t head,
  output logic               pop,
  lse_stream_if.source       item_out,
  output lse_pkg::lse_stat_t stat
);
  import lse_pkg::*;

  typedef struct packed {
    lse_phase_t  phase;
    logic [7:0]  header_count;
    logic [4:0]  bit_index;
    logic [3:0]  char_index;
    logic [31:0] payload_count;
  } lse_pos_t;

  localparam logic [3:0] MAGIC_MAX = 4'(MAX_MAGIC_CHARS);
  localparam logic [3:0] EXT_MAX   = 4'(MAX_EXT_CHARS);

  lse_pos_t      pos, pos_next, pos_pre, pos_step, pos_post;
  logic [7:0]    payload_hold, payload_hold_next;
  logic          payload_loaded, payload_loaded_next;
  logic          out_valid, out_valid_next;
  lse_out_item_t out_data, out_data_next;
  logic [3:0]    eff_magic_len, eff_ext_len;
  logic [31:0]   eff_ext_word;
  logic          out_free;
  logic          has_bit;
  logic          msg_bit;
  logic          underrun;

  // skip every section that is already complete
  function automatic lse_pos_t settle(lse_pos_t p, lse_cfg_t c,
                                      logic [3:0] em, logic [3:0] ee);
    lse_pos_t s;
    s = p;
    if (s.phase == PH_HEADER && s.header_count >= c.header_len) begin
      s.phase = PH_MAGIC;
      s.bit_index = '0;
      s.char_index = '0;
    end
    if (s.phase == PH_MAGIC && s.char_index >= em) begin
      s.phase = PH_EXTLEN;
      s.bit_index = '0;
      s.char_index = '0;
    end
    if (s.phase == PH_EXT && s.char_index >= ee) begin
      s.phase = PH_PSIZE;
      s.bit_index = '0;
      s.char_index = '0;
    end
    if (s.phase == PH_PAYLOAD && s.payload_count >= c.payload_size) begin
      s.phase = PH_DONE;
      s.bit_index = '0;
      s.char_index = '0;
    end
    return s;
  endfunction

  assign eff_magic_len = (cfg.magic_len > MAGIC_MAX) ? MAGIC_MAX : cfg.magic_len;
  assign eff_ext_len   = (cfg.ext_len > EXT_MAX) ? EXT_MAX : cfg.ext_len;
  assign eff_ext_word  = {28'd0, eff_ext_len};

  assign out_free = !out_valid || item_out.ready;
  assign pop      = head.valid && (head.cmd.op == OP_LOAD || out_free);

  always_comb begin
    pos_pre             = settle(pos, cfg, eff_magic_len, eff_ext_len);
    pos_step            = pos_pre;
    payload_hold_next   = payload_hold;
    payload_loaded_next = payload_loaded;
    has_bit             = 1'b0;
    msg_bit             = 1'b0;
    underrun            = 1'b0;

    unique case (pos_pre.phase)
      PH_HEADER: begin
        pos_step.header_count = pos_pre.header_count + 1'b1;
      end
      PH_MAGIC, PH_EXT: begin
        has_bit = 1'b1;
        msg_bit = (pos_pre.phase == PH_MAGIC)
                ? cfg.magic_chars[{pos_pre.char_index[2:0], ~pos_pre.bit_index[2:0]}]
                : cfg.ext_chars[{pos_pre.char_index[2:0], ~pos_pre.bit_index[2:0]}];
        if (pos_pre.bit_index[2:0] == 3'd7) begin
          pos_step.bit_index  = '0;
          pos_step.char_index = pos_pre.char_index + 1'b1;
        end else begin
          pos_step.bit_index = pos_pre.bit_index + 1'b1;
        end
      end
      PH_EXTLEN, PH_PSIZE: begin
        has_bit = 1'b1;
        msg_bit = (pos_pre.phase == PH_EXTLEN)
                ? eff_ext_word[~pos_pre.bit_index]
                : cfg.payload_size[~pos_pre.bit_index];
        if (pos_pre.bit_index == 5'd31) begin
          pos_step.phase      = (pos_pre.phase == PH_EXTLEN) ? PH_EXT : PH_PAYLOAD;
          pos_step.bit_index  = '0;
          pos_step.char_index = '0;
        end else begin
          pos_step.bit_index = pos_pre.bit_index + 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (!payload_loaded) begin
          underrun = 1'b1;
        end else begin
          has_bit = 1'b1;
          msg_bit = payload_hold[~pos_pre.bit_index[2:0]];
          if (pos_pre.bit_index[2:0] == 3'd7) begin
            pos_step.bit_index     = '0;
            pos_step.payload_count = pos_pre.payload_count + 1'b1;
          end else begin
            pos_step.bit_index = pos_pre.bit_index + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    pos_post = settle(pos_step, cfg, eff_magic_len, eff_ext_len);

    out_data_next.pixel_out = has_bit ? {head.cmd.value[7:1], msg_bit} : head.cmd.value;
    out_data_next.status    = underrun;
    out_data_next.done_res  = (pos_post.phase == PH_DONE);

    pos_next       = pos;
    out_valid_next = out_valid && !item_out.ready;

    if (pop) begin
      unique case (head.cmd.op)
        OP_LOAD: begin
          pos_next = pos_pre;
          if (!payload_loaded && pos_pre.phase != PH_DONE) begin
            payload_hold_next   = head.cmd.value;
            payload_loaded_next = 1'b1;
          end
        end
        OP_PIXEL: begin
          pos_next       = pos_post;
          out_valid_next = 1'b1;
          if (pos_pre.phase == PH_PAYLOAD && payload_loaded &&
              pos_pre.bit_index[2:0] == 3'd7) begin
            payload_loaded_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else begin
      payload_loaded_next = payload_loaded;
      payload_hold_next   = payload_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '{phase: PH_HEADER, default: '0};
      payload_loaded <= 1'b0;
      payload_hold   <= '0;
      out_valid      <= 1'b0;
    end else begin
      pos            <= pos_next;
      payload_loaded <= payload_loaded_next;
      payload_hold   <= payload_hold_next;
      out_valid      <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.cmd.op == OP_PIXEL) begin
      out_data <= out_data_next;
    end
  end

  assign item_out.valid = out_valid;
  assign item_out.data  = out_data;

  assign stat.phase  = pos.phase;
  assign stat.loaded = payload_loaded;
endmodule

// ===== hdl/lsb_stego_embedder.sv =====
// ---------------------------------------------------------------------------
// lsb_stego_embedder
// lsb steganography embedder: hides a short header and a payload in the
// least significant bits of an image byte stream
// ---------------------------------------------------------------------------
// The block takes one item per clock while its queue has room: an image
// byte (func 0) or a payload byte to load (func 1). Image bytes return one
// result each; payload loads return none. After header_len untouched bytes,
// each image byte carries one message bit in its lsb, msb first: the magic
// characters, the extension length as 32 bits, the extension characters,
// the payload size as 32 bits, then the payload bytes. A one-byte payload
// holding register feeds the payload section; an image byte that finds it
// empty passes unchanged with status 1 and the position is held. Items
// enter a small queue (QUEUE_DEPTH entries) in the front end; the back end
// sequencer takes one item from the queue head per cycle while results are
// taken. A result shows in the output register the cycle after its item is
// taken from the queue head, and the queue keeps input flowing while a
// result waits to be taken. Configuration is written through
// cfg_we/cfg_index/cfg_data and must only change while the block is idle.
// ---------------------------------------------------------------------------
module lsb_stego_embedder #(
  parameter int unsigned QUEUE_DEPTH = lse_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lse_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lse_pkg::CFG_DATA_W-1:0]  cfg_data,
  lse_stream_if.sink                      item_in,
  lse_stream_if.source                    item_out
);
  import lse_pkg::*;

  lse_cfg_t  cfg;
  lse_head_t head;
  logic      pop;
  lse_stat_t stat;

  // configuration registers; the user writes them only while idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_chars  <= '0;
      cfg.magic_len    <= MAGIC_LEN_RST;
      cfg.ext_chars    <= '0;
      cfg.ext_len      <= '0;
      cfg.payload_size <= '0;
      cfg.header_len   <= HEADER_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAGIC_CHARS:  cfg.magic_chars  <= cfg_data;
        REG_MAGIC_LEN:    cfg.magic_len    <= cfg_data[3:0];
        REG_EXT_CHARS:    cfg.ext_chars    <= cfg_data;
        REG_EXT_LEN:      cfg.ext_len      <= cfg_data[3:0];
        REG_PAYLOAD_SIZE: cfg.payload_size <= cfg_data[31:0];
        REG_HEADER_LEN:   cfg.header_len   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // front end: accept, tag and queue items
  lse_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .item_in (item_in),
    .head    (head),
    .pop     (pop)
  );

  // back end: section sequencer and result register
  lse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .pop      (pop),
    .item_out (item_out),
    .stat     (stat)
  );

`include "lsb_stego_embedder_macros.svh"

  // done is final: nothing leaves the done phase
  `LSE_ASSERT_NEXT(a_done_sticky, stat.phase == PH_DONE, stat.phase == PH_DONE, "done phase left")

  // a shown done flag matches the sequencer position
  `LSE_ASSERT_NOW(a_done_match, item_out.valid && item_out.data.done_res, stat.phase == PH_DONE, "done flag without done phase")

  // an underrun can only happen before the embedding completes
  `LSE_ASSERT_NOW(a_underrun_not_done, item_out.valid && item_out.data.status, !item_out.data.done_res, "underrun reported with done")

endmodule
